// ----- sv/run_length_expander_macros.svh -----
// Assertion macros shared by the run-length expander RTL.
`ifndef RUN_LENGTH_EXPANDER_MACROS_SVH
`define RUN_LENGTH_EXPANDER_MACROS_SVH

`ifndef ASSERT_OFF

`define RLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("run_length_expander: assertion failed");

`define RLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("run_length_expander: assertion failed");

`else

`define RLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define RLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/rle_pkg.sv -----
package rle_pkg;

	localparam int SYM_W     = 8;
	localparam int OFS_W     = 12;
	localparam int CNT_W     = 7;
	localparam int LANES     = 8;
	localparam int LANE_W    = 64;
	localparam int OUT_BYTES = 64;
	localparam int MAX_WORDS = 64;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [OFS_W-1:0] ofs_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		sym_t sym;
		ofs_t run_end;
	} pair_t;

	typedef struct packed {
		ofs_t total;
		logic eop;
	} grp_desc_t;

endpackage

// ----- sv/rle_ram.sv -----
module rle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/rle_front.sv -----
module rle_front
	import rle_pkg::*;
#(
	parameter int PAIRS           = 8,
	parameter int MAX_GROUP_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SYM_W-1:0]              symbol,
	input  logic [OFS_W-1:0]              run_end,
	input  logic                          group_last,
	input  logic                          packet_end,
	input  logic                          q_full,
	output logic                          wr_en,
	output logic [$clog2(2*PAIRS)-1:0]    wr_addr,
	output pair_t                         wr_data,
	output logic                          push,
	output grp_desc_t                     push_desc
);

	localparam int AW = $clog2(2*PAIRS);
	localparam int IW = PAIRS > 1 ? $clog2(PAIRS) : 1;

	logic [IW-1:0] idx_q;
	logic          bank_q;
	logic          accept;
	logic          close;
	ofs_t          sat_end;

	// both banks busy exactly when the queue holds two groups
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign sat_end = (run_end > OFS_W'(MAX_GROUP_BYTES - 1)) ?
		OFS_W'(MAX_GROUP_BYTES - 1) : run_end;
	assign close   = group_last || (idx_q == IW'(PAIRS - 1));

	assign wr_en           = accept;
	assign wr_addr         = bank_q ? AW'(PAIRS) + AW'(idx_q) : AW'(idx_q);
	assign wr_data.sym     = symbol;
	assign wr_data.run_end = sat_end;

	assign push            = accept && close;
	assign push_desc.total = sat_end;
	assign push_desc.eop   = packet_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (close) begin
				idx_q  <= '0;
				bank_q <= ~bank_q;
			end else begin
				idx_q <= IW'(idx_q + 1'b1);
			end
		end
	end

endmodule

// ----- sv/rle_queue.sv -----
`include "run_length_expander_macros.svh"

module rle_queue
	import rle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  grp_desc_t push_desc,
	input  logic      pop,
	output grp_desc_t head,
	output logic      nonempty,
	output logic      full
);

	grp_desc_t ent_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;

	assign head     = ent_q[rd_ptr_q];
	assign nonempty = cnt_q != 2'd0;
	assign full     = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`RLE_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full)
	`RLE_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, nonempty)

endmodule

// ----- sv/rle_back.sv -----
`include "run_length_expander_macros.svh"

module rle_back
	import rle_pkg::*;
#(
	parameter int PAIRS      = 8,
	parameter int WORD_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_nonempty,
	input  grp_desc_t                         head,
	output logic                              pop,
	output logic [$clog2(2*PAIRS)-1:0]        rd_addr,
	input  pair_t                             rd_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [LANES-1:0][LANE_W-1:0]      out_lanes,
	output logic [CNT_W-1:0]                  out_count,
	output logic                              out_eop,
	output logic                              out_last
);

	localparam int AW = $clog2(2*PAIRS);
	localparam int IW = PAIRS > 1 ? $clog2(PAIRS) : 1;

	logic [IW-1:0]                    k_q;
	logic                             bank_q;
	ofs_t                             off_q;
	ofs_t                             pos_q;
	cnt_t                             nwords_q;
	logic [OUT_BYTES-1:0][SYM_W-1:0]  word_q;
	logic                             primed_q;

	logic                             out_valid_q;
	logic [LANES-1:0][LANE_W-1:0]     lanes_q;
	cnt_t                             count_q;
	logic                             eop_q;
	logic                             last_q;

	ofs_t                             remain;
	logic                             final_word;
	cnt_t                             count;
	ofs_t                             word_end;
	ofs_t                             seg_end;
	logic                             skip;
	logic                             empty;
	cnt_t                             rel_lo;
	cnt_t                             rel_hi;
	logic [OUT_BYTES-1:0][SYM_W-1:0]  merged;
	logic                             go;
	logic                             out_free;
	logic                             done;
	logic                             emit;
	logic                             finish;
	logic [IW-1:0]                    k_next;
	logic                             bank_next;

	assign remain     = head.total - off_q;
	assign final_word = remain <= OFS_W'(WORD_BYTES);
	assign count      = final_word ? CNT_W'(remain) : CNT_W'(WORD_BYTES);
	assign word_end   = off_q + OFS_W'(count);
	assign empty      = count == '0;
	assign skip       = rd_data.run_end <= pos_q;
	assign seg_end    = (rd_data.run_end < word_end) ? rd_data.run_end : word_end;
	assign rel_lo     = CNT_W'(pos_q - off_q);
	assign rel_hi     = CNT_W'(seg_end - off_q);

	always_comb begin
		for (int b = 0; b < OUT_BYTES; b++) begin
			if (!empty && !skip && CNT_W'(b) >= rel_lo && CNT_W'(b) < rel_hi) begin
				merged[b] = rd_data.sym;
			end else begin
				merged[b] = word_q[b];
			end
		end
	end

	// store read data trails the address by one register; primed_q marks it current
	assign go       = q_nonempty && primed_q;
	assign out_free = !out_valid_q || !out_stall;
	assign done     = empty || (!skip && seg_end == word_end);
	assign emit     = go && done && out_free;
	assign finish   = emit && (final_word || nwords_q == CNT_W'(MAX_WORDS - 1));
	assign pop      = finish;

	always_comb begin
		if (finish) begin
			k_next = '0;
		end else if (go && !empty && skip) begin
			k_next = IW'(k_q + 1'b1);
		end else begin
			k_next = k_q;
		end
	end

	assign bank_next = bank_q ^ finish;
	assign rd_addr   = bank_next ? AW'(PAIRS) + AW'(k_next) : AW'(k_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			bank_q   <= 1'b0;
			off_q    <= '0;
			pos_q    <= '0;
			nwords_q <= '0;
			word_q   <= '0;
			primed_q <= 1'b0;
		end else begin
			primed_q <= q_nonempty && !finish;
			k_q      <= k_next;
			bank_q   <= bank_next;
			if (go && (empty || !skip)) begin
				if (!done) begin
					word_q <= merged;
					pos_q  <= seg_end;
				end else if (out_free) begin
					word_q <= '0;
					if (finish) begin
						off_q    <= '0;
						pos_q    <= '0;
						nwords_q <= '0;
					end else begin
						off_q    <= word_end;
						pos_q    <= word_end;
						nwords_q <= nwords_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			lanes_q <= merged;
			count_q <= count;
			eop_q   <= final_word && head.eop;
			last_q  <= final_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_lanes = lanes_q;
	assign out_count = count_q;
	assign out_eop   = eop_q;
	assign out_last  = last_q;

	`RLE_ASSERT_IMPLY(a_pos_in_word, clk, arst_n, go && !empty, pos_q >= off_q && pos_q < word_end)
	`RLE_ASSERT_NEXT(a_group_rewind, clk, arst_n, finish, k_q == '0 && off_q == '0 && nwords_q == '0)

endmodule

// ----- sv/run_length_expander.sv -----
// A group's first word is built only after its closing pair is taken and queued.
// Throughput: pairs are taken one per cycle while one of the two store banks is free.
// Each word merges each run it touches and steps past each run skipped; each group
// first waits for the store read data. The scan over the stored runs is the limit.
// Reset: arst_n clears all control state and the partial word; no clearing pass.
module run_length_expander
	import rle_pkg::*;
#(
	parameter int PAIRS_PER_GROUP = 8,
	parameter int WORD_BYTES      = 64,
	parameter int MAX_GROUP_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [OFS_W-1:0]  run_end,
	input  logic              group_last,
	input  logic              packet_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LANE_W-1:0] lane0,
	output logic [LANE_W-1:0] lane1,
	output logic [LANE_W-1:0] lane2,
	output logic [LANE_W-1:0] lane3,
	output logic [LANE_W-1:0] lane4,
	output logic [LANE_W-1:0] lane5,
	output logic [LANE_W-1:0] lane6,
	output logic [LANE_W-1:0] lane7,
	output logic [CNT_W-1:0]  valid_bytes,
	output logic              word_eop,
	output logic              word_last
);

	localparam int AW = $clog2(2*PAIRS_PER_GROUP);

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	pair_t                         wr_data;
	logic [AW-1:0]                 rd_addr;
	pair_t                         rd_data;
	logic                          push;
	grp_desc_t                     push_desc;
	logic                          pop;
	grp_desc_t                     head;
	logic                          q_nonempty;
	logic                          q_full;
	logic [LANES-1:0][LANE_W-1:0]  lanes;

	rle_front #(
		.PAIRS           (PAIRS_PER_GROUP),
		.MAX_GROUP_BYTES (MAX_GROUP_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.run_end    (run_end),
		.group_last (group_last),
		.packet_end (packet_end),
		.q_full     (q_full),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push       (push),
		.push_desc  (push_desc)
	);

	rle_ram #(
		.WIDTH ($bits(pair_t)),
		.DEPTH (2*PAIRS_PER_GROUP)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.nonempty  (q_nonempty),
		.full      (q_full)
	);

	rle_back #(
		.PAIRS      (PAIRS_PER_GROUP),
		.WORD_BYTES (WORD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_lanes  (lanes),
		.out_count  (valid_bytes),
		.out_eop    (word_eop),
		.out_last   (word_last)
	);

	assign lane0 = lanes[0];
	assign lane1 = lanes[1];
	assign lane2 = lanes[2];
	assign lane3 = lanes[3];
	assign lane4 = lanes[4];
	assign lane5 = lanes[5];
	assign lane6 = lanes[6];
	assign lane7 = lanes[7];

endmodule

// ----- test/tb_run_length_expander.sv -----
module tb_run_length_expander;

	timeunit 1ns;
	timeprecision 1ps;

	import rle_pkg::*;

	localparam int PAIRS_PER_GROUP = 8;
	localparam int CYCLE_LIMIT     = 800000;
	localparam int HOLD_CYCLES     = 300;

	typedef struct packed {
		sym_t sym;
		ofs_t ends;
		logic closes;
		logic eop;
	} rle_pair_t;

	typedef struct packed {
		logic [LANES-1:0][LANE_W-1:0] lanes;
		cnt_t count;
		logic eop;
		logic last;
	} rle_word_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [SYM_W-1:0]  symbol      = '0;
	logic [OFS_W-1:0]  run_end     = '0;
	logic              group_last  = 1'b0;
	logic              packet_end  = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [LANE_W-1:0] lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7;
	logic [CNT_W-1:0]  valid_bytes;
	logic              word_eop;
	logic              word_last;

	rle_pair_t pending_pairs[$];
	rle_word_t expected_words[$];

	sym_t run_sym[PAIRS_PER_GROUP];
	ofs_t run_stop[PAIRS_PER_GROUP];
	int   runs_held   = 0;

	int   errors      = 0;
	int   pairs_taken = 0;
	int   words_seen  = 0;
	int   cycles      = 0;
	logic hold        = 1'b0;

	run_length_expander u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.run_end    (run_end),
		.group_last (group_last),
		.packet_end (packet_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lane0      (lane0),
		.lane1      (lane1),
		.lane2      (lane2),
		.lane3      (lane3),
		.lane4      (lane4),
		.lane5      (lane5),
		.lane6      (lane6),
		.lane7      (lane7),
		.valid_bytes(valid_bytes),
		.word_eop   (word_eop),
		.word_last  (word_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (errors < 50)
			$display("mismatch: word %0d %s got %h exp %h", words_seen, what, got, want);
		errors++;
	endtask

	task automatic queue_pair(input sym_t s, input int e, input logic c, input logic f);
		rle_pair_t p;
		p.sym    = s;
		p.ends   = ofs_t'(e);
		p.closes = c;
		p.eop    = f;
		pending_pairs.push_back(p);
	endtask

	function automatic sym_t run_symbol_at(input int pos);
		int k;
		for (k = 0; k < runs_held; k++)
			if (pos < int'(run_stop[k]))
				return run_sym[k];
		return '0;
	endfunction

	// store the pair; on group close, expand into words
	task automatic expand_pair(input rle_pair_t p);
		rle_word_t w;
		int total, ofs, remain, cnt, n, b;
		logic tail;
		if (runs_held >= PAIRS_PER_GROUP)
			runs_held = 0;
		run_sym[runs_held]  = p.sym;
		run_stop[runs_held] = p.ends;
		runs_held++;
		if (!p.closes && runs_held < PAIRS_PER_GROUP)
			return;
		total = int'(p.ends);
		ofs = 0;
		n = 0;
		do begin
			remain = total - ofs;
			tail = (remain <= OUT_BYTES);
			cnt = tail ? remain : OUT_BYTES;
			w = '0;
			for (b = 0; b < cnt; b++)
				w.lanes[b / 8][(b % 8) * 8 +: 8] = run_symbol_at(ofs + b);
			w.count = cnt_t'(cnt);
			w.eop = tail ? p.eop : 1'b0;
			w.last = tail;
			expected_words.push_back(w);
			n++;
			ofs += OUT_BYTES;
		end while (!tail && n < MAX_WORDS);
		runs_held = 0;
	endtask

	// input driver
	rle_pair_t cur_pair;
	int        gap_left = 0;
	logic      burst_in = 1'b0;

	always @(posedge clk) begin : pair_driver
		logic busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				expand_pair(cur_pair);
				pairs_taken++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_pairs.size() > 0) begin
					cur_pair = pending_pairs.pop_front();
					symbol <= cur_pair.sym;
					run_end <= cur_pair.ends;
					group_last <= cur_pair.closes;
					packet_end <= cur_pair.eop;
					busy = 1'b1;
					if ($urandom_range(0, 19) == 0)
						burst_in = ~burst_in;
					gap_left = burst_in ? 0 : $urandom_range(0, 3);
				end
			end
			in_valid <= busy;
		end
	end

	// output monitor
	int   stall_left = 0;
	logic burst_out  = 1'b0;

	always @(posedge clk) begin : word_monitor
		rle_word_t w;
		logic [LANES-1:0][LANE_W-1:0] got;
		int i;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {lane7, lane6, lane5, lane4, lane3, lane2, lane1, lane0};
				if (expected_words.size() == 0) begin
					report("unexpected word, valid_bytes", 64'(valid_bytes), 64'd0);
				end else begin
					w = expected_words.pop_front();
					for (i = 0; i < LANES; i++)
						if (got[i] !== w.lanes[i])
							report($sformatf("lane%0d", i), got[i], w.lanes[i]);
					if (valid_bytes !== w.count)
						report("valid_bytes", 64'(valid_bytes), 64'(w.count));
					if (word_eop !== w.eop)
						report("word_eop", 64'(word_eop), 64'(w.eop));
					if (word_last !== w.last)
						report("word_last", 64'(word_last), 64'(w.last));
				end
				words_seen++;
				if ($urandom_range(0, 19) == 0)
					burst_out = ~burst_out;
				stall_left = burst_out ? 0 : $urandom_range(0, 3);
			end
			out_stall <= hold || (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pairs_taken >= 40);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[run_length_expander] ERROR");
			$finish;
		end
	end

	initial begin
		int n, total, prev, e, kind, i;
		logic noise;

		// empty groups
		queue_pair(8'h5A, 0, 1'b1, 1'b1);
		queue_pair(8'hFF, 0, 1'b1, 1'b0);
		// exactly one full word
		queue_pair(8'hFF, 64, 1'b1, 1'b0);
		// spills one byte into a second word
		queue_pair(8'h00, 30, 1'b0, 1'b0);
		queue_pair(8'h11, 65, 1'b1, 1'b1);
		// largest group
		queue_pair(8'hA5, 4095, 1'b1, 1'b1);
		// store fills and closes without group_last
		for (i = 0; i < PAIRS_PER_GROUP; i++)
			queue_pair(sym_t'(8'h80 + i), 5 * (i + 1), 1'b0, 1'b1);
		// ends out of order, zero-length runs
		queue_pair(8'h21, 50, 1'b0, 1'b0);
		queue_pair(8'h22, 20, 1'b0, 1'b0);
		queue_pair(8'h23, 70, 1'b0, 1'b0);
		queue_pair(8'h24, 60, 1'b1, 1'b0);
		// earlier run reaches past the group total
		queue_pair(8'h31, 200, 1'b0, 1'b0);
		queue_pair(8'h32, 10, 1'b1, 1'b1);

		while (pending_pairs.size() < 156) begin
			n = $urandom_range(1, PAIRS_PER_GROUP);
			kind = $urandom_range(0, 9);
			if (kind == 0)
				total = $urandom_range(0, 4095);
			else if (kind == 1)
				total = 0;
			else
				total = $urandom_range(1, 200);
			noise = ($urandom_range(0, 6) == 0);
			prev = 0;
			for (i = 0; i < n - 1; i++) begin
				if (noise) begin
					e = $urandom_range(0, 4095);
				end else begin
					e = $urandom_range(prev, total);
					prev = e;
				end
				queue_pair(sym_t'($urandom), e, 1'b0, 1'($urandom));
			end
			queue_pair(sym_t'($urandom), total,
				(n < PAIRS_PER_GROUP) ? 1'b1 : 1'($urandom), 1'($urandom));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_pairs.size() == 0 && !in_valid);
		wait (expected_words.size() == 0);
		repeat (40) @(posedge clk);
		if (expected_words.size() != 0)
			report("words still expected", 64'(expected_words.size()), 64'd0);
		if (errors == 0)
			$display("[run_length_expander] OK");
		else
			$display("[run_length_expander] ERROR");
		$finish;
	end

endmodule
